FILE: sv/wheel_encoder_odometry_unit_defines.svh
// Assertion macros used by the odometry RTL.
`ifndef WHEEL_ENCODER_ODOMETRY_UNIT_DEFINES_SVH
`define WHEEL_ENCODER_ODOMETRY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset
`define WEODO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define WEODO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WEODO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define WEODO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/weodo_pkg.sv
// Package: constants, types and sequencer states for the wheel odometry unit.
package weodo_pkg;

    // Encoder geometry
    localparam int COUNTS_PER_REV = 3200;
    localparam int COUNT_STEP     = 2;
    localparam int POS_W          = 12;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TURNS_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int VEL_W    = 29;
    localparam int RADIUS_W = 16;
    localparam int PROD_W   = VEL_W + RADIUS_W;
    localparam int DIV_W    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Velocity numerator: COUNT_STEP * 2pi * 1e6 * 2^16 / COUNTS_PER_REV, rounded
    localparam longint unsigned TWO_PI_E6_Q16 = 64'd411774832291;
    localparam longint unsigned VEL_K_L =
        (TWO_PI_E6_Q16 * COUNT_STEP + COUNTS_PER_REV / 2) / COUNTS_PER_REV;
    localparam logic [DIV_W-1:0] VEL_K = VEL_K_L[DIV_W-1:0];

    // Saturation limits of the 29-bit velocity fields
    localparam logic [VEL_W-1:0] VEL_POS_MAX = 29'h0FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_NEG_MAX = 29'h1000_0000;

    // Register reset value: 0.074 m in Q0.16
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd4850;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Per-request wheel tracking results
    typedef struct packed {
        logic               up;
        logic               zero;
        logic [TIME_W-1:0]  delta;
        logic [POS_W-1:0]   pos;
        logic [TURNS_W-1:0] turns;
        logic [TOTAL_W-1:0] total;
    } track_t;

endpackage

FILE: sv/wheel_encoder_odometry_unit.sv
// Top level: two-wheel quadrature odometry with period-based velocity.
//
// Each request is one channel-A edge of one wheel. Position, turns and total
// count update at acceptance; velocity is found by a shared restoring divider
// that produces one quotient bit per cycle and flags completion through a
// registered done, followed by a radius multiply and a load of the output
// register. The input is ready again once the result is in the output
// register; a zero delta skips the divider. A result that cannot leave
// because the previous one still waits holds the sequencer in its done state.
// The input is not ready while a request is in work, but a finished result
// waits in the output register while the next request is taken. Zero delta
// saturates the velocity and sets zero_interval. The user must write
// wheel_radius only while the unit is idle; the unit does not enforce this.
`include "wheel_encoder_odometry_unit_defines.svh"

module wheel_encoder_odometry_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration: wheel_radius
    input  logic                                 cfg_we,
    input  logic [weodo_pkg::RADIUS_W-1:0]       cfg_wdata,
    // Request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [weodo_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // chan_a, chan_b, time_us, pad
    input  logic                                 s_axis_tuser,  // wheel_sel
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // rev_count, turns, total_count, ang_vel, lin_vel, pad
    output logic [weodo_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic [weodo_pkg::M_TUSER_W-1:0]      m_axis_tuser   // wheel_id, zero_interval
);

    weodo_pkg::state_t             state_reg;
    weodo_pkg::state_t             state_next;

    logic [weodo_pkg::RADIUS_W-1:0] radius_reg;

    logic                           job_wheel_reg;
    logic                           job_neg_reg;
    logic                           job_zero_reg;
    logic [weodo_pkg::POS_W-1:0]    job_pos_reg;
    logic [weodo_pkg::TURNS_W-1:0]  job_turns_reg;
    logic [weodo_pkg::TOTAL_W-1:0]  job_total_reg;
    logic [weodo_pkg::VEL_W-1:0]    amag_reg;
    logic [weodo_pkg::PROD_W-1:0]   prod_reg;

    logic                           out_valid_reg;
    logic [weodo_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic [weodo_pkg::M_TUSER_W-1:0] out_tuser_reg;

    logic                           accept;
    logic                           div_start;
    logic                           amag_load;
    logic                           prod_load;
    logic                           out_load;
    logic                           out_free;

    weodo_pkg::track_t              track;
    weodo_pkg::div_stat_t           div_stat;
    logic [weodo_pkg::DIV_W-1:0]    quotient;
    logic [weodo_pkg::DIV_W-1:0]    dividend;

    logic [weodo_pkg::PROD_W-1:0]   prod_round;
    logic [weodo_pkg::VEL_W-1:0]    lmag;
    logic [weodo_pkg::VEL_W-1:0]    ang_vel;
    logic [weodo_pkg::VEL_W-1:0]    lin_vel;

    logic                           chk_in_div;
    logic                           chk_zero_out;
    logic                           chk_ang_sat;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Wheel state
    weodo_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (accept),
        .wheel_sel (s_axis_tuser),
        .chan_a    (s_axis_tdata[0]),
        .chan_b    (s_axis_tdata[1]),
        .time_us   (s_axis_tdata[33:2]),
        .track     (track)
    );

    // Rounded quotient: (K + delta/2) / delta
    assign dividend = weodo_pkg::VEL_K + {1'b0, track.delta[weodo_pkg::TIME_W-1:1]};

    weodo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (track.delta),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            weodo_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = track.zero ? weodo_pkg::ST_MUL : weodo_pkg::ST_DIV;
                end
            end
            weodo_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = weodo_pkg::ST_MUL;
                end
            end
            weodo_pkg::ST_MUL:
            begin
                state_next = weodo_pkg::ST_DONE;
            end
            weodo_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = weodo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = weodo_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        amag_load     = 1'b0;
        prod_load     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            weodo_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                div_start     = s_axis_tvalid && !track.zero;
            end
            weodo_pkg::ST_DIV:
            begin
                amag_load = div_stat.done;
            end
            weodo_pkg::ST_MUL:
            begin
                prod_load = 1'b1;
            end
            weodo_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= weodo_pkg::ST_IDLE;
            radius_reg    <= weodo_pkg::RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, velocity and radius product
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_wheel_reg <= s_axis_tuser;
            job_neg_reg   <= ~track.up;
            job_zero_reg  <= track.zero;
            job_pos_reg   <= track.pos;
            job_turns_reg <= track.turns;
            job_total_reg <= track.total;
            amag_reg      <= track.up ? weodo_pkg::VEL_POS_MAX : weodo_pkg::VEL_NEG_MAX;
        end
        else if (amag_load)
        begin
            // quotient never exceeds K, which is below the positive limit
            amag_reg <= quotient[weodo_pkg::VEL_W-1:0];
        end
        if (prod_load)
        begin
            prod_reg <= weodo_pkg::PROD_W'(amag_reg) * weodo_pkg::PROD_W'(radius_reg);
        end
    end

    // Rounding of the linear velocity and sign application
    always_comb
    begin
        prod_round = prod_reg + weodo_pkg::PROD_W'(32768);
        lmag       = prod_round[weodo_pkg::PROD_W-1:16];
        ang_vel    = job_neg_reg ? (weodo_pkg::VEL_W'(0) - amag_reg) : amag_reg;
        lin_vel    = job_neg_reg ? (weodo_pkg::VEL_W'(0) - lmag) : lmag;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_tdata_reg <= {2'b00, lin_vel, ang_vel, job_total_reg, job_turns_reg,
                              job_pos_reg};
            out_tuser_reg <= {job_zero_reg, job_wheel_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

    // Check terms
    assign chk_in_div   = (state_reg == weodo_pkg::ST_DIV);
    assign chk_zero_out = m_axis_tvalid && m_axis_tuser[1];
    assign chk_ang_sat  = (m_axis_tdata[88:60] == weodo_pkg::VEL_POS_MAX)
                       || (m_axis_tdata[88:60] == weodo_pkg::VEL_NEG_MAX);

    // Checks
    `WEODO_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !s_axis_tready, "ready after accept")
    `WEODO_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_stat.done, chk_in_div, "done outside divide")
    `WEODO_ASSERT_IMP(a_zero_saturates, clk, rst_n, chk_zero_out, chk_ang_sat, "zero not saturated")

endmodule

FILE: sv/weodo_div.sv
// Restoring divider: one quotient bit per cycle through a shared subtract/compare.
module weodo_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [weodo_pkg::DIV_W-1:0]    dividend,
    input  logic [weodo_pkg::DIV_W-1:0]    divisor,
    output logic [weodo_pkg::DIV_W-1:0]    quotient,
    output weodo_pkg::div_stat_t           stat
);

    logic [weodo_pkg::DIV_W-1:0]     rem_reg;
    logic [weodo_pkg::DIV_W-1:0]     quo_reg;
    logic [weodo_pkg::DIV_W-1:0]     dsr_reg;
    logic [weodo_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [weodo_pkg::DIV_W:0]       shifted;
    logic [weodo_pkg::DIV_W:0]       diff;
    logic                            ge;
    logic [weodo_pkg::DIV_W-1:0]     rem_next;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[weodo_pkg::DIV_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = ~diff[weodo_pkg::DIV_W];
        rem_next = ge ? diff[weodo_pkg::DIV_W-1:0] : shifted[weodo_pkg::DIV_W-1:0];
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= weodo_pkg::DIV_CNT_W'(weodo_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[weodo_pkg::DIV_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sv/weodo_track.sv
// Per-wheel position, turn, total and timestamp tracking.
module weodo_track
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            update,
    input  logic                            wheel_sel,
    input  logic                            chan_a,
    input  logic                            chan_b,
    input  logic [weodo_pkg::TIME_W-1:0]    time_us,
    output weodo_pkg::track_t               track
);

    logic [weodo_pkg::POS_W-1:0]   pos_reg   [2];
    logic [weodo_pkg::TURNS_W-1:0] turns_reg [2];
    logic [weodo_pkg::TOTAL_W-1:0] total_reg [2];
    logic [weodo_pkg::TIME_W-1:0]  time_reg  [2];

    logic                          up;
    logic [weodo_pkg::POS_W:0]     pos_up;
    logic [weodo_pkg::POS_W-1:0]   pos_cur;
    logic [weodo_pkg::TURNS_W-1:0] turns_cur;

    // Direction and wrapped position step
    always_comb
    begin
        up        = (chan_a == chan_b) ? ~wheel_sel : wheel_sel;
        pos_cur   = pos_reg[wheel_sel];
        turns_cur = turns_reg[wheel_sel];
        pos_up    = {1'b0, pos_cur} + (weodo_pkg::POS_W + 1)'(weodo_pkg::COUNT_STEP);

        track.up    = up;
        track.delta = time_us - time_reg[wheel_sel];
        track.zero  = (track.delta == '0);
        if (up)
        begin
            track.total = total_reg[wheel_sel]
                        + weodo_pkg::TOTAL_W'(weodo_pkg::COUNT_STEP);
            if (pos_up > (weodo_pkg::POS_W + 1)'(weodo_pkg::COUNTS_PER_REV))
            begin
                track.pos   = weodo_pkg::POS_W'(pos_up
                            - (weodo_pkg::POS_W + 1)'(weodo_pkg::COUNTS_PER_REV));
                track.turns = turns_cur + 1'b1;
            end
            else
            begin
                track.pos   = pos_up[weodo_pkg::POS_W-1:0];
                track.turns = turns_cur;
            end
        end
        else
        begin
            track.total = total_reg[wheel_sel]
                        - weodo_pkg::TOTAL_W'(weodo_pkg::COUNT_STEP);
            if (pos_cur < weodo_pkg::POS_W'(weodo_pkg::COUNT_STEP))
            begin
                track.pos   = pos_cur + weodo_pkg::POS_W'(weodo_pkg::COUNTS_PER_REV
                            - weodo_pkg::COUNT_STEP);
                track.turns = turns_cur - 1'b1;
            end
            else
            begin
                track.pos   = pos_cur - weodo_pkg::POS_W'(weodo_pkg::COUNT_STEP);
                track.turns = turns_cur;
            end
        end
    end

    // State write-back on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                pos_reg[i]   <= '0;
                turns_reg[i] <= '0;
                total_reg[i] <= '0;
                time_reg[i]  <= '0;
            end
        end
        else if (update)
        begin
            pos_reg[wheel_sel]   <= track.pos;
            turns_reg[wheel_sel] <= track.turns;
            total_reg[wheel_sel] <= track.total;
            time_reg[wheel_sel]  <= time_us;
        end
    end

endmodule
